// ===== hdl/ctrw_pkg.sv =====
package ctrw_pkg;

    // default store depth in cells
    localparam int TEXT_CAPACITY_DEF = 16384;

    // register reset values
    localparam logic [8:0]  WIDTH_RESET = 9'd38;
    localparam logic [14:0] LINES_RESET = 15'd431;
    localparam logic [13:0] ROW_RESET   = 14'(LINES_RESET - 15'd1);

    // register limits
    localparam logic [8:0]  WIDTH_MAX = 9'd256;
    localparam logic [14:0] LINES_MAX = 15'd16384;

    // register indexes on the config port
    localparam logic CFG_LINE_WIDTH  = 1'b0;
    localparam logic CFG_TOTAL_LINES = 1'b1;

    // item functions
    localparam logic FUNC_PRINT = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    // character codes
    localparam logic [7:0] CH_NUL      = 8'd0;
    localparam logic [7:0] CH_COLOUR_A = 8'd1;
    localparam logic [7:0] CH_COLOUR_B = 8'd2;
    localparam logic [7:0] CH_NL       = 8'd10;
    localparam logic [7:0] CH_CR       = 8'd13;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] COLOUR_MASK = 8'h80;

    typedef struct packed {
        logic        func;
        logic [7:0]  ch;
        logic        start_of_message;
        logic [8:0]  word_len;
        logic [13:0] read_address;
    } item_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [13:0] row;
        logic [7:0]  column;
        logic        line_started;
    } result_t;

    typedef struct packed {
        logic [8:0]  line_width;
        logic [14:0] total_lines;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_READ,
        ST_PREP,
        ST_ADV,
        ST_MUL,
        ST_CLR,
        ST_PUT,
        ST_DONE
    } ctrw_state_t;

endpackage

// ===== hdl/ctrw_store.sv =====
module ctrw_store #(
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [7:0]               wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [7:0]               rdata
);

    logic [7:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hdl/ctrw_seq.sv =====
module ctrw_seq #(
    parameter int TEXT_CAPACITY = ctrw_pkg::TEXT_CAPACITY_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  ctrw_pkg::cfg_t                   cfg,
    input  logic                             item_valid,
    output logic                             item_stall,
    input  ctrw_pkg::item_t                  item,
    output logic                             res_valid,
    input  logic                             res_ready,
    output ctrw_pkg::result_t                res,
    output logic                             mem_we,
    output logic [$clog2(TEXT_CAPACITY)-1:0] mem_waddr,
    output logic [7:0]                       mem_wdata,
    output logic                             mem_re,
    output logic [$clog2(TEXT_CAPACITY)-1:0] mem_raddr,
    input  logic [7:0]                       mem_rdata
);

    import ctrw_pkg::*;

    localparam int AW = $clog2(TEXT_CAPACITY);
    localparam logic [AW-1:0] SWEEP_LAST = AW'(TEXT_CAPACITY - 1);
    localparam logic [23:0]   CAP_LIMIT  = 24'(TEXT_CAPACITY);
    localparam logic [31:0]   CAP_WORD   = 32'(TEXT_CAPACITY);

    ctrw_state_t state_reg, state_next;
    logic [13:0] row_reg, row_next;
    logic [7:0]  col_reg, col_next;
    logic        pend_reg, pend_next;
    logic        colour_reg, colour_next;
    logic        started_reg, started_next;
    logic [AW-1:0] sweep_reg, sweep_next;
    logic [8:0]  cnt_reg, cnt_next;
    logic [22:0] base_reg, base_next;
    item_t       item_reg, item_next;

    logic [8:0]  w_eff;
    logic [14:0] n_eff;
    logic [13:0] n_last;
    logic [8:0]  wl_cap;
    logic        wrap;
    logic [13:0] row_back;
    logic [13:0] row_fwd;
    logic [7:0]  col_inc;
    logic [8:0]  off;
    logic [23:0] sum;
    logic        in_range;
    logic        read_ok;
    logic        colour_byte;

    // effective register values
    always_comb
    begin
        priority if (cfg.line_width == 9'd0)
            w_eff = 9'd1;
        else if (cfg.line_width > WIDTH_MAX)
            w_eff = WIDTH_MAX;
        else
            w_eff = cfg.line_width;

        priority if (cfg.total_lines == 15'd0)
            n_eff = 15'd1;
        else if (cfg.total_lines > LINES_MAX)
            n_eff = LINES_MAX;
        else
            n_eff = cfg.total_lines;
    end

    assign n_last = 14'(n_eff - 15'd1);

    // cursor arithmetic
    assign wl_cap   = (item_reg.word_len > w_eff) ? w_eff : item_reg.word_len;
    assign wrap     = (wl_cap != w_eff) &&
                      ((10'(col_reg) + 10'(wl_cap)) > 10'(w_eff));
    assign row_back = ((row_reg == 14'd0) || (15'(row_reg) >= n_eff)) ?
                      n_last : row_reg - 14'd1;
    assign row_fwd  = ((15'(row_reg) + 15'd1) >= n_eff) ? 14'd0 : row_reg + 14'd1;
    assign col_inc  = ((9'(col_reg) + 9'd1) >= w_eff) ? 8'd0 : col_reg + 8'd1;

    assign colour_byte = (item_reg.ch == CH_COLOUR_A) || (item_reg.ch == CH_COLOUR_B);

    // shared address adder: row base plus clear index or column
    assign off      = (state_reg == ST_CLR) ? cnt_reg : 9'(col_reg);
    assign sum      = 24'(base_reg) + 24'(off);
    assign in_range = (sum < CAP_LIMIT);

    assign read_ok   = (32'(item_reg.read_address) < CAP_WORD);
    assign mem_raddr = AW'(item_reg.read_address);

    // result fields
    always_comb
    begin
        res.read_data    = ((item_reg.func == FUNC_READ) && read_ok) ? mem_rdata : 8'd0;
        res.row          = row_reg;
        res.column       = col_reg;
        res.line_started = started_reg;
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_SWEEP;
            row_reg     <= ROW_RESET;
            col_reg     <= 8'd0;
            pend_reg    <= 1'b0;
            colour_reg  <= 1'b0;
            started_reg <= 1'b0;
            sweep_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            pend_reg    <= pend_next;
            colour_reg  <= colour_next;
            started_reg <= started_next;
            sweep_reg   <= sweep_next;
        end
    end

    // item and address payload
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        cnt_reg  <= cnt_next;
        base_reg <= base_next;
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        pend_next    = pend_reg;
        colour_next  = colour_reg;
        started_next = started_reg;
        sweep_next   = sweep_reg;
        cnt_next     = cnt_reg;
        base_next    = base_reg;
        item_next    = item_reg;
        mem_we       = 1'b0;
        mem_waddr    = AW'(sum);
        mem_wdata    = CH_SPACE;
        mem_re       = 1'b0;
        res_valid    = 1'b0;
        item_stall   = 1'b1;

        unique case (state_reg)
            ST_SWEEP:
            begin
                mem_we     = 1'b1;
                mem_waddr  = sweep_reg;
                sweep_next = sweep_reg + AW'(1);
                if (sweep_reg == SWEEP_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                item_stall = 1'b0;
                if (item_valid)
                begin
                    item_next    = item;
                    started_next = 1'b0;
                    priority if (item.func == FUNC_READ)
                        state_next = ST_READ;
                    else if (item.ch == CH_NUL)
                        state_next = ST_DONE;
                    else
                        state_next = ST_PREP;
                end
            end
            ST_READ:
            begin
                mem_re     = 1'b1;
                state_next = ST_DONE;
            end
            ST_PREP:
            begin
                if (item_reg.start_of_message && colour_byte)
                begin
                    colour_next = 1'b1;
                    state_next  = ST_DONE;
                end
                else
                begin
                    if (item_reg.start_of_message)
                    begin
                        colour_next = 1'b0;
                    end
                    if (wrap)
                    begin
                        col_next = 8'd0;
                    end
                    if (pend_reg)
                    begin
                        row_next  = row_back;
                        pend_next = 1'b0;
                    end
                    state_next = ST_ADV;
                end
            end
            ST_ADV:
            begin
                if (col_reg == 8'd0)
                begin
                    row_next     = row_fwd;
                    started_next = 1'b1;
                end
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                base_next  = 23'(row_reg) * 23'(w_eff);
                cnt_next   = 9'd0;
                state_next = started_reg ? ST_CLR : ST_PUT;
            end
            ST_CLR:
            begin
                mem_we   = in_range;
                cnt_next = cnt_reg + 9'd1;
                if (cnt_reg == (w_eff - 9'd1))
                begin
                    state_next = ST_PUT;
                end
            end
            ST_PUT:
            begin
                priority if (item_reg.ch == CH_NL)
                begin
                    col_next = 8'd0;
                end
                else if (item_reg.ch == CH_CR)
                begin
                    col_next  = 8'd0;
                    pend_next = 1'b1;
                end
                else
                begin
                    mem_we    = in_range;
                    mem_wdata = item_reg.ch | (colour_reg ? COLOUR_MASK : 8'd0);
                    col_next  = col_inc;
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sweep hands over to idle once the last cell is cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP) && (sweep_reg == SWEEP_LAST) |=> (state_reg == ST_IDLE))
        else $error("reset sweep did not finish");

    // a row clear only follows a row advance
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLR) |-> started_reg)
        else $error("row clear without line start");

    // advancing keeps the row inside the ring
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ADV) && (col_reg == 8'd0) |=> (15'(row_reg) < n_eff))
        else $error("row left the ring");

    // after a stored character the column is inside the line
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PUT) |=> (9'(col_reg) < w_eff))
        else $error("column beyond line width");

endmodule

// ===== hdl/console_text_ring_writer.sv =====
// Character-cell scrollback ring with word wrap, newline and carriage return.
// item channel (item_valid / item_stall / item): func 0 prints one character,
// func 1 reads one stored cell. result channel (result_valid / result_stall /
// result): exactly one beat per item, carrying the read byte and the cursor.
// cfg_write / cfg_index / cfg_data set line_width (0) and total_lines (1);
// write them only while no item is in flight.
// Steps after an item is accepted: a read goes through READ to DONE, an
// ignored print (NUL) goes straight to DONE and a dropped colour byte passes
// PREP; a print steps through PREP, ADV, MUL and PUT to DONE, with a row
// clear (CLR) before PUT when the print opens a new row, which writes one
// cell a cycle through the single store write port. A new item is taken on
// the cycle after the result is handed to the output register, so the next
// item is not taken while one is still being worked off.
// After reset the store is swept to spaces, one cell a cycle, with item_stall
// high until every cell is written. Config writes are taken during the sweep.
// A stalled result holds in the output register; one more item can be taken
// and worked off meanwhile, then item_stall stays high until the beat leaves.
module console_text_ring_writer #(
    parameter int TEXT_CAPACITY = ctrw_pkg::TEXT_CAPACITY_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  ctrw_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output ctrw_pkg::result_t result,
    input  logic              cfg_write,
    input  logic              cfg_index,
    input  logic [14:0]       cfg_data
);

    import ctrw_pkg::*;

    localparam int AW = $clog2(TEXT_CAPACITY);

    cfg_t    cfg_reg;
    logic    res_valid;
    logic    res_ready;
    result_t res;
    logic    out_valid_reg;
    result_t out_reg;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    mem_rdata;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.line_width  <= WIDTH_RESET;
            cfg_reg.total_lines <= LINES_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_LINE_WIDTH:  cfg_reg.line_width  <= cfg_data[8:0];
                CFG_TOTAL_LINES: cfg_reg.total_lines <= cfg_data;
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    ctrw_seq #(
        .TEXT_CAPACITY(TEXT_CAPACITY)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_re     (mem_re),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata)
    );

    ctrw_store #(
        .DEPTH(TEXT_CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // output register parts the sequencer from the receiver
    assign res_ready = !out_valid_reg || !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule
